[src/pending_request_response_collector_unit_macros.svh]
// Assertion macros shared by the collector RTL.
`ifndef PENDING_REQUEST_RESPONSE_COLLECTOR_UNIT_MACROS_SVH
`define PENDING_REQUEST_RESPONSE_COLLECTOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define PRCC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("collector check failed");

// Check that a condition implies a consequence in the same cycle.
`define PRCC_ASSERT_IMPLY(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("collector implication failed");

`else

`define PRCC_ASSERT(label, clk, rst_n, prop)
`define PRCC_ASSERT_IMPLY(label, clk, rst_n, cond, cons)

`endif

`endif

[src/prcc_pkg.sv]
`default_nettype none

package prcc_pkg;

    localparam int ENTRIES = 8;
    localparam int WORDS   = 16;
    localparam int IDX_W   = $clog2(ENTRIES);

    // Configuration register indexes
    localparam logic REG_OWNER_IS_HOME       = 1'b0;
    localparam logic REG_IS_TRANSLATION_UNIT = 1'b1;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_RESP  = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_ALLOCATED  = 3'd0,
        ST_TABLE_FULL = 3'd1,
        ST_PARTIAL    = 3'd2,
        ST_COMPLETED  = 3'd3,
        ST_NO_MATCH   = 3'd4
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_MOD  = 1'b1
    } state_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  txn_id;
        logic        line_grain;
        logic [15:0] word_mask;
        logic [31:0] stamp_hm;
        logic [31:0] stamp_sp;
    } in_beat_t;

    typedef struct packed {
        status_t     status;
        logic [2:0]  slot;
        logic [31:0] done_hm;
        logic [31:0] done_sp;
        logic        forward_to_device;
        logic [31:0] home_wait_hm;
        logic [31:0] home_wait_sp;
    } out_beat_t;

    // One table entry as held in the entry memory
    typedef struct packed {
        logic [WORDS-1:0] got;
        logic [31:0]      hm;
        logic [31:0]      sp;
    } entry_t;

endpackage

`default_nettype wire

[src/prcc_ram.sv]
`default_nettype none

module prcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, register one read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[src/pending_request_response_collector_unit.sv]
// channel | direction | handshake           | payload
// --------+-----------+---------------------+-------------------------------
// in      | input     | in_valid / in_ready   | in_data (prcc_pkg::in_beat_t)
// out     | output    | out_valid / out_ready | out_data (prcc_pkg::out_beat_t)
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A beat is accepted in S_IDLE and modified in S_MOD. The accept cycle matches ids
// and picks a free slot against the flop-based id and valid table and issues the
// entry memory read; S_MOD modifies the entry, writes it back and loads the result
// register, and holds while the result register is still full and not taken.
// Reset clears valid bits, age order and wait maxima at once; no clearing pass.
// Configuration writes are taken in any cycle.
`default_nettype none

`include "pending_request_response_collector_unit_macros.svh"

module pending_request_response_collector_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire prcc_pkg::in_beat_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output prcc_pkg::out_beat_t      out_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_index,
    input  wire logic                cfg_data
);

    localparam int N  = prcc_pkg::ENTRIES;
    localparam int IW = prcc_pkg::IDX_W;
    localparam int EW = $bits(prcc_pkg::entry_t);

    prcc_pkg::state_t    state_reg, state_next;
    prcc_pkg::in_beat_t  item_reg;
    logic [IW-1:0]       slot_reg;
    logic                hit_reg;
    logic [N-1:0]        valid_reg, valid_next;
    logic [N-1:0]        older_reg [N];
    logic [N-1:0]        older_next [N];
    logic [7:0]          id_reg [N];
    logic [31:0]         wait_hm_reg, wait_hm_next;
    logic [31:0]         wait_sp_reg, wait_sp_next;
    logic                owner_is_home_reg;
    logic                is_translation_unit_reg;
    logic                out_valid_reg, out_valid_next;
    prcc_pkg::out_beat_t out_reg, out_next;

    logic                in_fire;
    logic                mod_fire;
    logic [N-1:0]        match;
    logic [N-1:0]        oldest;
    logic [IW-1:0]       free_idx;
    logic [IW-1:0]       hit_idx;
    logic [IW-1:0]       look_slot;
    logic                look_hit;
    logic                ram_we;
    logic                id_we;
    prcc_pkg::entry_t    ram_wdata;
    logic [EW-1:0]       ram_rdata;
    prcc_pkg::entry_t    rd_entry;
    logic [prcc_pkg::WORDS-1:0] item_mask;
    logic [prcc_pkg::WORDS-1:0] got_new;
    logic [31:0]         hm_new, sp_new;
    logic                done;

    assign in_ready  = (state_reg == prcc_pkg::S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign mod_fire  = (state_reg == prcc_pkg::S_MOD) && (!out_valid_reg || out_ready);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Match ids of the incoming beat and pick the oldest hit and lowest free slot
    always_comb
    begin
        free_idx = '0;
        hit_idx  = '0;
        for (int i = 0; i < N; i++)
        begin
            match[i] = valid_reg[i] && (id_reg[i] == in_data.txn_id);
        end
        for (int i = 0; i < N; i++)
        begin
            oldest[i] = match[i] && ((older_reg[i] & match) == '0);
            if (oldest[i])
            begin
                hit_idx = hit_idx | IW'(i);
            end
        end
        for (int i = N - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IW'(i);
            end
        end
        if (in_data.op == prcc_pkg::OP_ALLOC)
        begin
            look_slot = free_idx;
            look_hit  = !(&valid_reg);
        end
        else
        begin
            look_slot = hit_idx;
            look_hit  = |match;
        end
    end

    prcc_ram #(
        .WIDTH (EW),
        .DEPTH (N)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (ram_wdata),
        .re    (in_fire),
        .raddr (look_slot),
        .rdata (ram_rdata)
    );

    assign rd_entry  = prcc_pkg::entry_t'(ram_rdata);
    assign item_mask = item_reg.word_mask[prcc_pkg::WORDS-1:0];
    assign got_new   = rd_entry.got | item_mask;
    assign hm_new    = (rd_entry.hm < item_reg.stamp_hm) ? item_reg.stamp_hm : rd_entry.hm;
    assign sp_new    = (rd_entry.sp < item_reg.stamp_sp) ? item_reg.stamp_sp : rd_entry.sp;
    assign done      = item_reg.line_grain || (&got_new);

    // Sequence the beat, modify the entry and build the result
    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        older_next     = older_reg;
        wait_hm_next   = wait_hm_reg;
        wait_sp_next   = wait_sp_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        ram_we         = 1'b0;
        id_we          = 1'b0;
        ram_wdata      = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            prcc_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = prcc_pkg::S_MOD;
                end
            end
            prcc_pkg::S_MOD:
            begin
                if (mod_fire)
                begin
                    state_next = prcc_pkg::S_IDLE;
                    out_valid_next = 1'b1;
                    out_next.status = prcc_pkg::ST_NO_MATCH;
                    out_next.slot = 3'(slot_reg);
                    out_next.done_hm = '0;
                    out_next.done_sp = '0;
                    out_next.forward_to_device = 1'b0;
                    if (item_reg.op == prcc_pkg::OP_ALLOC)
                    begin
                        if (hit_reg)
                        begin
                            out_next.status = prcc_pkg::ST_ALLOCATED;
                            ram_we = 1'b1;
                            id_we = 1'b1;
                            ram_wdata.got = ~item_mask;
                            ram_wdata.hm = item_reg.stamp_hm;
                            ram_wdata.sp = item_reg.stamp_sp;
                            valid_next[slot_reg] = 1'b1;
                            for (int j = 0; j < N; j++)
                            begin
                                older_next[j][slot_reg] = 1'b0;
                            end
                            older_next[slot_reg] = valid_reg;
                        end
                        else
                        begin
                            out_next.status = prcc_pkg::ST_TABLE_FULL;
                            out_next.slot = '0;
                        end
                    end
                    else if (hit_reg)
                    begin
                        ram_we = 1'b1;
                        ram_wdata.got = got_new;
                        ram_wdata.hm = hm_new;
                        ram_wdata.sp = sp_new;
                        if (done)
                        begin
                            out_next.status = prcc_pkg::ST_COMPLETED;
                            out_next.done_hm = hm_new;
                            out_next.done_sp = sp_new;
                            out_next.forward_to_device = is_translation_unit_reg;
                            valid_next[slot_reg] = 1'b0;
                            if (owner_is_home_reg)
                            begin
                                if (wait_hm_reg < hm_new)
                                begin
                                    wait_hm_next = hm_new;
                                end
                                if (wait_sp_reg < sp_new)
                                begin
                                    wait_sp_next = sp_new;
                                end
                            end
                        end
                        else
                        begin
                            out_next.status = prcc_pkg::ST_PARTIAL;
                        end
                    end
                    else
                    begin
                        out_next.slot = '0;
                    end
                    out_next.home_wait_hm = wait_hm_next;
                    out_next.home_wait_sp = wait_sp_next;
                end
            end
            default:
            begin
                state_next = prcc_pkg::S_IDLE;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg               <= prcc_pkg::S_IDLE;
            valid_reg               <= '0;
            wait_hm_reg             <= '0;
            wait_sp_reg             <= '0;
            out_valid_reg           <= 1'b0;
            owner_is_home_reg       <= 1'b0;
            is_translation_unit_reg <= 1'b0;
            for (int i = 0; i < N; i++)
            begin
                older_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            wait_hm_reg   <= wait_hm_next;
            wait_sp_reg   <= wait_sp_next;
            out_valid_reg <= out_valid_next;
            older_reg     <= older_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    prcc_pkg::REG_OWNER_IS_HOME:       owner_is_home_reg       <= cfg_data;
                    prcc_pkg::REG_IS_TRANSLATION_UNIT: is_translation_unit_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Hold the accepted beat, its slot and the result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= in_data;
            slot_reg <= look_slot;
            hit_reg  <= look_hit;
        end
        if (id_we)
        begin
            id_reg[slot_reg] <= item_reg.txn_id;
        end
        out_reg <= out_next;
    end

    `PRCC_ASSERT(a_result_from_modify, clk, rst_n, $rose(out_valid_reg) |-> $past(state_reg == prcc_pkg::S_MOD))
    `PRCC_ASSERT(a_valid_changes_on_modify, clk, rst_n, !$past(mod_fire) |-> $stable(valid_reg))
    `PRCC_ASSERT_IMPLY(a_alloc_slot_free, clk, rst_n, (state_reg == prcc_pkg::S_MOD) && (item_reg.op == prcc_pkg::OP_ALLOC) && hit_reg, !valid_reg[slot_reg])
    `PRCC_ASSERT_IMPLY(a_resp_slot_valid, clk, rst_n, (state_reg == prcc_pkg::S_MOD) && (item_reg.op == prcc_pkg::OP_RESP) && hit_reg, valid_reg[slot_reg])

endmodule

`default_nettype wire
